@@ src/keypad_scan_debounce_defines.svh @@
// Assertion macros for the keypad scanner block.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef KEYPAD_SCAN_DEBOUNCE_DEFINES_SVH
`define KEYPAD_SCAN_DEBOUNCE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define KPD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define KPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/kpd_pkg.sv @@
// Shared types and constants for the keypad scanner block.
// No dependencies.
package kpd_pkg;

  localparam int unsigned CodeW  = 4;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CountW-1:0] PressTicksRst   = 8'd33;
  localparam logic [CountW-1:0] ReleaseTicksRst = 8'd32;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] CfgPressTicks   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgReleaseTicks = 2'd1;

  typedef struct packed {
    logic              we;
    logic [CfgIdxW-1:0] index;
    logic [CountW-1:0] wdata;
  } cfg_wr_t;

  // One result word, last field in the lowest bits when packed to tdata
  typedef struct packed {
    logic             buzzer_level;
    logic             release_seen;
    logic             key_valid;
    logic [CodeW-1:0] key_idx;
    logic [CodeW-1:0] column_select;
  } result_t;

endpackage

@@ src/keypad_scan_debounce.sv @@
// 4x4 keypad scanner with press debounce, release detection and buzzer.
// Each accepted tick word gives a registered result word, offered in the next cycle.
// Throughput: one tick word per cycle; input stalls only while a result word waits.
// Reset (synchronous, rst_n low): registers back to 33/32, counters
// reloaded, scan index, flags, buzzer and key code cleared, output empty.
// Depends on kpd_pkg, kpd_core, kpd_outreg and keypad_scan_debounce_defines.svh.
`include "keypad_scan_debounce_defines.svh"

module keypad_scan_debounce import kpd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // Configuration write port
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CountW-1:0]  cfg_wdata,
  // Tick word in
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [3:0] row_lines, [4] ack, [7:5] zero
  // Result word out
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [15:0]        out_tdata   // [3:0] column_select, [7:4] key_idx,
                                         // [8] key_valid, [9] release_seen,
                                         // [10] buzzer_level, [15:11] zero
);

  cfg_wr_t cfg_wr;
  result_t core_result;
  result_t out_word;
  logic    can_load;
  logic    in_accept;

  assign cfg_wr.we    = cfg_we;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.wdata = cfg_wdata;

  // Take a new tick whenever the result register is free or draining now
  assign in_tready = can_load;
  assign in_accept = in_tvalid && in_tready;

  // Scan and debounce state; advance only on an accepted tick
  kpd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_wr),
    .step      (in_accept),
    .row_lines (in_tdata[3:0]),
    .ack       (in_tdata[4]),
    .result    (core_result)
  );

  // Hold the result word until the sink takes it
  kpd_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .result    (core_result),
    .can_load  (can_load),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = {5'b0, out_word};

  // An accepted tick always leaves a result word behind
  `KPD_ASSERT_NEXT(a_tick_gives_word, in_accept, out_tvalid, "tick word lost")
  // Exactly one column driven low in every result
  `KPD_ASSERT_NOW(a_one_column, out_tvalid, $countones(~out_tdata[3:0]) == 1, "column not one-hot")
  // Release can only be flagged on a confirmed key
  `KPD_ASSERT_NOW(a_rel_needs_rdy, out_tvalid && out_tdata[9], out_tdata[8], "release w/o key")
  // A full, stalled output register must not be overwritten
  `KPD_ASSERT_NEXT(a_hold_stalled, out_tvalid && !out_tready, $stable(out_tdata), "stall broken")

endmodule

@@ src/kpd_core.sv @@
// Scan, debounce, release and buzzer state of the keypad scanner.
// Depends on kpd_pkg.
module kpd_core import kpd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_wr_t          cfg_wr,
  input  logic             step,
  input  logic [3:0]       row_lines,
  input  logic             ack,
  output result_t          result
);

  logic [CountW-1:0] press_ticks_r, press_ticks_nxt;
  logic [CountW-1:0] release_ticks_r, release_ticks_nxt;
  logic [CodeW-1:0]  scan_index_r, scan_index_nxt;
  logic [CountW-1:0] press_cnt_r, press_cnt_nxt;
  logic [CountW-1:0] rel_cnt_r, rel_cnt_nxt;
  logic              ready_r, ready_nxt;
  logic              released_r, released_nxt;
  logic              buzz_act_r, buzz_act_nxt;
  logic              buzz_lvl_r, buzz_lvl_nxt;
  logic [CodeW-1:0]  held_code_r, held_code_nxt;

  logic              pressed;
  logic [CountW-1:0] press_dec;
  logic [CountW-1:0] rel_dec;

  assign pressed   = ~row_lines[scan_index_r[1:0]];
  assign press_dec = press_cnt_r - 8'd1;
  assign rel_dec   = rel_cnt_r - 8'd1;

  always_comb begin
    press_ticks_nxt   = press_ticks_r;
    release_ticks_nxt = release_ticks_r;
    scan_index_nxt    = scan_index_r;
    press_cnt_nxt     = press_cnt_r;
    rel_cnt_nxt       = rel_cnt_r;
    ready_nxt         = ready_r;
    released_nxt      = released_r;
    buzz_act_nxt      = buzz_act_r;
    buzz_lvl_nxt      = buzz_lvl_r;
    held_code_nxt     = held_code_r;

    if (cfg_wr.we) begin
      // Load the register and reload its counter
      if (cfg_wr.index == CfgPressTicks) begin
        press_ticks_nxt = cfg_wr.wdata;
        press_cnt_nxt   = cfg_wr.wdata;
      end else if (cfg_wr.index == CfgReleaseTicks) begin
        release_ticks_nxt = cfg_wr.wdata;
        rel_cnt_nxt       = cfg_wr.wdata;
      end
    end else if (step) begin
      if (buzz_act_r) begin
        buzz_lvl_nxt = ~buzz_lvl_r;
      end

      if (!ready_r) begin
        if (press_cnt_r == press_ticks_r) begin
          // Idle: a press latches the code and starts the down-count
          if (pressed) begin
            press_cnt_nxt = press_dec;
            held_code_nxt = scan_index_r;
          end
        end else if (press_dec == '0) begin
          press_cnt_nxt = press_ticks_r;
          if (pressed) begin
            ready_nxt    = 1'b1;
            buzz_act_nxt = 1'b1;
          end
        end else begin
          press_cnt_nxt = press_dec;
        end
      end else begin
        if (pressed) begin
          rel_cnt_nxt = release_ticks_r;
        end else if (rel_dec == '0) begin
          released_nxt = 1'b1;
          buzz_act_nxt = 1'b0;
          rel_cnt_nxt  = release_ticks_r;
        end else begin
          rel_cnt_nxt = rel_dec;
        end
      end

      if (ack && released_nxt) begin
        ready_nxt    = 1'b0;
        released_nxt = 1'b0;
      end

      scan_index_nxt = scan_index_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      press_ticks_r   <= PressTicksRst;
      release_ticks_r <= ReleaseTicksRst;
      scan_index_r    <= '0;
      press_cnt_r     <= PressTicksRst;
      rel_cnt_r       <= ReleaseTicksRst;
      ready_r         <= 1'b0;
      released_r      <= 1'b0;
      buzz_act_r      <= 1'b0;
      buzz_lvl_r      <= 1'b0;
      held_code_r     <= '0;
    end else begin
      press_ticks_r   <= press_ticks_nxt;
      release_ticks_r <= release_ticks_nxt;
      scan_index_r    <= scan_index_nxt;
      press_cnt_r     <= press_cnt_nxt;
      rel_cnt_r       <= rel_cnt_nxt;
      ready_r         <= ready_nxt;
      released_r      <= released_nxt;
      buzz_act_r      <= buzz_act_nxt;
      buzz_lvl_r      <= buzz_lvl_nxt;
      held_code_r     <= held_code_nxt;
    end
  end

  // Result shows the state after this tick; column from the sampled index
  always_comb begin
    result.column_select = ~(4'b0001 << scan_index_r[3:2]);
    result.key_idx       = held_code_nxt;
    result.key_valid     = ready_nxt;
    result.release_seen  = released_nxt;
    result.buzzer_level  = buzz_lvl_nxt;
  end

endmodule

@@ src/kpd_outreg.sv @@
// Output register of the keypad scanner: holds one result word for the sink.
// Depends on kpd_pkg.
module kpd_outreg import kpd_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t result,
  output logic    can_load,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_word
);

  logic    valid_r, valid_nxt;
  result_t word_r;

  assign can_load = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule
